// ===== hdl/fpbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpbc_pkg
// Shared constants and helpers for the front panel button controller:
// configuration register indexes, register reset values and bit-map helpers.
// ----------------------------------------------------------------------------
package fpbc_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STORED_PANEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STORED_BOOT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_CODES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MAP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE        = 3'd7;

  // Field widths
  localparam int PAT_W  = 8;
  localparam int MAP_W  = 18;
  localparam int TICK_W = 10;

  // Default elapsed-counter width
  localparam int TIMER_BITS_DEF = 10;

  // Register reset values
  localparam logic [MAP_W-1:0]  MAP_RST        = 18'd181896;
  localparam logic [TICK_W-1:0] REPEAT_RST     = 10'd300;
  localparam logic [TICK_W-1:0] LONG_PRESS_RST = 10'd800;
  localparam logic [TICK_W-1:0] LOCKOUT_RST    = 10'd500;
  localparam logic [TICK_W-1:0] PULSE_RST      = 10'd50;

  // Slots of the bit map
  localparam int SLOT_HDMI_LED = 0;
  localparam int SLOT_KB_SEL   = 1;
  localparam int SLOT_KB_LED   = 2;
  localparam int SLOT_DISP_LED = 3;
  localparam int SLOT_SEL1_LED = 4;
  localparam int SLOT_SEL2_LED = 5;

  // One-hot pattern mask for a bit-map slot
  function automatic logic [PAT_W-1:0] slot_mask(input logic [MAP_W-1:0] map,
                                                 input int slot);
    logic [2:0] pos;
    pos = map[3*slot +: 3];
    return PAT_W'(1) << pos;
  endfunction

endpackage

// ===== hdl/front_panel_button_controller_unit.sv =====
// ----------------------------------------------------------------------------
// front_panel_button_controller_unit
// A result is registered in the cycle after its tick is transferred.
// Throughput: one tick per clock; the output register and the input side
// advance together whenever the result is taken or the register is empty.
// Reset (rst_n low, synchronous): all state and patterns cleared, timing
// registers back to their defaults, output register empty.
// ----------------------------------------------------------------------------
// Front panel button controller: per 1 ms tick, handles pattern toggles,
// boot-button press length, display-mode line pulses and external select.
// ----------------------------------------------------------------------------
module front_panel_button_controller_unit
  import fpbc_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // tick input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_device_acks,
  input  logic                  in_hdmi_btn_low,
  input  logic                  in_kb_btn_low,
  input  logic                  in_boot_btn_low,
  input  logic                  in_up_btn_low,
  input  logic                  in_down_btn_low,
  input  logic                  in_select_btn_low,
  input  logic                  in_ext_select_low,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PAT_W-1:0]      out_panel_pattern,
  output logic [PAT_W-1:0]      out_boot_pattern,
  output logic                  out_send_panel,
  output logic                  out_send_boot,
  output logic                  out_save_patterns,
  output logic                  out_restore_hdmi_pulse,
  output logic                  out_up_line_low,
  output logic                  out_down_line_low,
  output logic                  out_select_line_low,
  output logic                  out_display_mode
);

  localparam int                  CMP_W = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  typedef enum logic [1:0] {
    BOOT_IDLE,
    BOOT_PRESSED,
    BOOT_LOCKOUT
  } boot_phase_t;

  typedef enum logic [1:0] {
    PULSE_UP,
    PULSE_DOWN,
    PULSE_SELECT
  } pulse_line_t;

  // Configuration registers
  logic [CFG_DATA_W-1:0] boot_codes_r;
  logic [MAP_W-1:0]      bit_map_r;
  logic [TICK_W-1:0]     repeat_r, long_press_r, lockout_r, pulse_len_r;

  // Controller state
  logic                  started_r, started_nxt;
  logic [PAT_W-1:0]      panel_bits_r, panel_bits_nxt;
  logic [PAT_W-1:0]      boot_bits_r, boot_bits_nxt;
  logic                  hdmi_armed_r, hdmi_armed_nxt;
  logic [TIMER_BITS-1:0] hdmi_elapsed_r, hdmi_elapsed_nxt;
  logic                  kb_armed_r, kb_armed_nxt;
  logic [TIMER_BITS-1:0] kb_elapsed_r, kb_elapsed_nxt;
  boot_phase_t           boot_phase_r, boot_phase_nxt;
  logic [TIMER_BITS-1:0] boot_elapsed_r, boot_elapsed_nxt;
  logic                  display_on_r, display_on_nxt;
  logic                  pulse_busy_r, pulse_busy_nxt;
  pulse_line_t           pulse_which_r, pulse_which_nxt;
  logic [TIMER_BITS-1:0] pulse_elapsed_r, pulse_elapsed_nxt;
  logic                  ext_armed_r, ext_armed_nxt;
  logic [TIMER_BITS-1:0] ext_elapsed_r, ext_elapsed_nxt;

  // Result register
  logic                  out_valid_r;
  logic                  send_panel_r, send_panel_nxt;
  logic                  send_boot_r, send_boot_nxt;
  logic                  save_r, save_nxt;
  logic                  restore_r, restore_nxt;
  logic [PAT_W-1:0]      out_panel_r, out_boot_r;
  logic                  up_line_r, down_line_r, sel_line_r, disp_mode_r;

  // Saturating counter increments
  logic [TIMER_BITS-1:0] hdmi_inc, kb_inc, boot_inc, pulse_inc, ext_inc;

  // Bit-map masks
  logic [PAT_W-1:0]      m_hdmi, m_kb, m_disp, m_sel1, m_sel2;

  logic                  in_fire;
  logic [1:0]            boot_sel;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign m_hdmi = slot_mask(bit_map_r, SLOT_HDMI_LED);
  assign m_kb   = slot_mask(bit_map_r, SLOT_KB_SEL) | slot_mask(bit_map_r, SLOT_KB_LED);
  assign m_disp = slot_mask(bit_map_r, SLOT_DISP_LED);
  assign m_sel1 = slot_mask(bit_map_r, SLOT_SEL1_LED);
  assign m_sel2 = slot_mask(bit_map_r, SLOT_SEL2_LED);

  // Advance elapsed counters, hold at the top
  assign hdmi_inc  = (hdmi_elapsed_r  == TMAX) ? TMAX : hdmi_elapsed_r  + 1'b1;
  assign kb_inc    = (kb_elapsed_r    == TMAX) ? TMAX : kb_elapsed_r    + 1'b1;
  assign boot_inc  = (boot_elapsed_r  == TMAX) ? TMAX : boot_elapsed_r  + 1'b1;
  assign pulse_inc = (pulse_elapsed_r == TMAX) ? TMAX : pulse_elapsed_r + 1'b1;
  assign ext_inc   = (ext_elapsed_r   == TMAX) ? TMAX : ext_elapsed_r   + 1'b1;

  // Per-tick update
  always_comb begin
    started_nxt       = started_r;
    panel_bits_nxt    = panel_bits_r;
    boot_bits_nxt     = boot_bits_r;
    hdmi_armed_nxt    = hdmi_armed_r;
    hdmi_elapsed_nxt  = hdmi_elapsed_r;
    kb_armed_nxt      = kb_armed_r;
    kb_elapsed_nxt    = kb_elapsed_r;
    boot_phase_nxt    = boot_phase_r;
    boot_elapsed_nxt  = boot_elapsed_r;
    display_on_nxt    = display_on_r;
    pulse_busy_nxt    = pulse_busy_r;
    pulse_which_nxt   = pulse_which_r;
    pulse_elapsed_nxt = pulse_elapsed_r;
    ext_armed_nxt     = ext_armed_r;
    ext_elapsed_nxt   = ext_elapsed_r;
    send_panel_nxt    = 1'b0;
    send_boot_nxt     = 1'b0;
    save_nxt          = 1'b0;
    restore_nxt       = 1'b0;
    boot_sel          = 2'd0;

    if (!started_r) begin
      // Wait for the probe acknowledge, then send both patterns
      if (in_device_acks) begin
        send_panel_nxt = 1'b1;
        send_boot_nxt  = 1'b1;
        restore_nxt    = |(panel_bits_r & m_hdmi);
        started_nxt    = 1'b1;
      end
    end else begin
      hdmi_elapsed_nxt  = hdmi_inc;
      kb_elapsed_nxt    = kb_inc;
      boot_elapsed_nxt  = boot_inc;
      pulse_elapsed_nxt = pulse_inc;
      ext_elapsed_nxt   = ext_inc;

      // End the running pulse
      if (pulse_busy_r && (CMP_W'(pulse_inc) > CMP_W'(pulse_len_r))) begin
        pulse_busy_nxt = 1'b0;
      end

      // HDMI toggle with hold repeat
      if (in_hdmi_btn_low && (!hdmi_armed_r || (CMP_W'(hdmi_inc) > CMP_W'(repeat_r)))) begin
        panel_bits_nxt   = panel_bits_nxt ^ m_hdmi;
        send_panel_nxt   = 1'b1;
        save_nxt         = 1'b1;
        hdmi_elapsed_nxt = '0;
        hdmi_armed_nxt   = 1'b1;
      end

      // KB toggle with hold repeat
      if (in_kb_btn_low && (!kb_armed_r || (CMP_W'(kb_inc) > CMP_W'(repeat_r)))) begin
        panel_bits_nxt = panel_bits_nxt ^ m_kb;
        send_panel_nxt = 1'b1;
        save_nxt       = 1'b1;
        kb_elapsed_nxt = '0;
        kb_armed_nxt   = 1'b1;
      end

      // Boot button: act on release by press length, then lock out
      unique case (boot_phase_r)
        BOOT_PRESSED: begin
          if (!in_boot_btn_low) begin
            if (CMP_W'(boot_inc) > CMP_W'(long_press_r)) begin
              display_on_nxt = !display_on_r;
              if (!display_on_r) begin
                panel_bits_nxt = panel_bits_nxt | m_disp;
              end else begin
                panel_bits_nxt = panel_bits_nxt & ~m_disp;
              end
            end else begin
              unique case ({|(panel_bits_nxt & m_sel1), |(panel_bits_nxt & m_sel2)})
                2'b00: begin
                  panel_bits_nxt = panel_bits_nxt | m_sel1;
                  boot_sel       = 2'd1;
                end
                2'b10: begin
                  panel_bits_nxt = (panel_bits_nxt & ~m_sel1) | m_sel2;
                  boot_sel       = 2'd2;
                end
                2'b01: begin
                  panel_bits_nxt = panel_bits_nxt | m_sel1;
                  boot_sel       = 2'd3;
                end
                default: begin
                  panel_bits_nxt = panel_bits_nxt & ~(m_sel1 | m_sel2);
                  boot_sel       = 2'd0;
                end
              endcase
              boot_bits_nxt = boot_codes_r[8*boot_sel +: 8];
              send_boot_nxt = 1'b1;
            end
            send_panel_nxt   = 1'b1;
            save_nxt         = 1'b1;
            boot_elapsed_nxt = '0;
            boot_phase_nxt   = BOOT_LOCKOUT;
          end
        end
        BOOT_LOCKOUT: begin
          if (CMP_W'(boot_inc) > CMP_W'(lockout_r)) begin
            boot_phase_nxt = BOOT_IDLE;
          end
        end
        default: begin
          boot_phase_nxt = BOOT_IDLE;
          if (in_boot_btn_low) begin
            boot_elapsed_nxt = '0;
            boot_phase_nxt   = BOOT_PRESSED;
          end
        end
      endcase

      // Start a line pulse, up over down over select
      if (display_on_nxt && !pulse_busy_nxt) begin
        priority if (in_up_btn_low) begin
          pulse_which_nxt   = PULSE_UP;
          pulse_busy_nxt    = 1'b1;
          pulse_elapsed_nxt = '0;
        end else if (in_down_btn_low) begin
          pulse_which_nxt   = PULSE_DOWN;
          pulse_busy_nxt    = 1'b1;
          pulse_elapsed_nxt = '0;
        end else if (in_select_btn_low) begin
          pulse_which_nxt   = PULSE_SELECT;
          pulse_busy_nxt    = 1'b1;
          pulse_elapsed_nxt = '0;
        end
      end

      // External select request enables display mode
      if (!display_on_nxt && !pulse_busy_nxt && in_ext_select_low &&
          (!ext_armed_r || (CMP_W'(ext_inc) > CMP_W'(repeat_r)))) begin
        display_on_nxt  = 1'b1;
        panel_bits_nxt  = panel_bits_nxt | m_disp;
        send_panel_nxt  = 1'b1;
        save_nxt        = 1'b1;
        ext_elapsed_nxt = '0;
        ext_armed_nxt   = 1'b1;
      end
    end
  end

  // Hold state, configuration and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_codes_r    <= '0;
      bit_map_r       <= MAP_RST;
      repeat_r        <= REPEAT_RST;
      long_press_r    <= LONG_PRESS_RST;
      lockout_r       <= LOCKOUT_RST;
      pulse_len_r     <= PULSE_RST;
      started_r       <= 1'b0;
      panel_bits_r    <= '0;
      boot_bits_r     <= '0;
      hdmi_armed_r    <= 1'b0;
      hdmi_elapsed_r  <= '0;
      kb_armed_r      <= 1'b0;
      kb_elapsed_r    <= '0;
      boot_phase_r    <= BOOT_IDLE;
      boot_elapsed_r  <= '0;
      display_on_r    <= 1'b0;
      pulse_busy_r    <= 1'b0;
      pulse_which_r   <= PULSE_UP;
      pulse_elapsed_r <= '0;
      ext_armed_r     <= 1'b0;
      ext_elapsed_r   <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      // Drop the result once taken, load a new one on each input transfer
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (in_fire) begin
        started_r       <= started_nxt;
        panel_bits_r    <= panel_bits_nxt;
        boot_bits_r     <= boot_bits_nxt;
        hdmi_armed_r    <= hdmi_armed_nxt;
        hdmi_elapsed_r  <= hdmi_elapsed_nxt;
        kb_armed_r      <= kb_armed_nxt;
        kb_elapsed_r    <= kb_elapsed_nxt;
        boot_phase_r    <= boot_phase_nxt;
        boot_elapsed_r  <= boot_elapsed_nxt;
        display_on_r    <= display_on_nxt;
        pulse_busy_r    <= pulse_busy_nxt;
        pulse_which_r   <= pulse_which_nxt;
        pulse_elapsed_r <= pulse_elapsed_nxt;
        ext_armed_r     <= ext_armed_nxt;
        ext_elapsed_r   <= ext_elapsed_nxt;
      end

      // Configuration writes; stored patterns load straight into the state
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_STORED_PANEL: panel_bits_r <= cfg_wdata[PAT_W-1:0] & ~m_disp;
          REG_STORED_BOOT:  boot_bits_r  <= cfg_wdata[PAT_W-1:0];
          REG_BOOT_CODES:   boot_codes_r <= cfg_wdata;
          REG_BIT_MAP:      bit_map_r    <= cfg_wdata[MAP_W-1:0];
          REG_REPEAT:       repeat_r     <= cfg_wdata[TICK_W-1:0];
          REG_LONG_PRESS:   long_press_r <= cfg_wdata[TICK_W-1:0];
          REG_LOCKOUT:      lockout_r    <= cfg_wdata[TICK_W-1:0];
          REG_PULSE:        pulse_len_r  <= cfg_wdata[TICK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_panel_r  <= panel_bits_nxt;
      out_boot_r   <= boot_bits_nxt;
      send_panel_r <= send_panel_nxt;
      send_boot_r  <= send_boot_nxt;
      save_r       <= save_nxt;
      restore_r    <= restore_nxt;
      up_line_r    <= pulse_busy_nxt && (pulse_which_nxt == PULSE_UP);
      down_line_r  <= pulse_busy_nxt && (pulse_which_nxt == PULSE_DOWN);
      sel_line_r   <= pulse_busy_nxt && (pulse_which_nxt == PULSE_SELECT);
      disp_mode_r  <= display_on_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_panel_pattern      = out_panel_r;
  assign out_boot_pattern       = out_boot_r;
  assign out_send_panel         = send_panel_r;
  assign out_send_boot          = send_boot_r;
  assign out_save_patterns      = save_r;
  assign out_restore_hdmi_pulse = restore_r;
  assign out_up_line_low        = up_line_r;
  assign out_down_line_low      = down_line_r;
  assign out_select_line_low    = sel_line_r;
  assign out_display_mode       = disp_mode_r;

endmodule

// ===== verif/panel_result_checker.sv =====
// ----------------------------------------------------------------------------
// panel_result_checker
// Watches the tick, result and register-write ports of the front panel
// button controller. Predicts the result of each transferred tick from its
// own copy of the controller state and compares it field by field with the
// oldest pending result.
// ----------------------------------------------------------------------------
module panel_result_checker
  import fpbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_device_acks,
  input  logic                  in_hdmi_btn_low,
  input  logic                  in_kb_btn_low,
  input  logic                  in_boot_btn_low,
  input  logic                  in_up_btn_low,
  input  logic                  in_down_btn_low,
  input  logic                  in_select_btn_low,
  input  logic                  in_ext_select_low,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [PAT_W-1:0]      out_panel_pattern,
  input  logic [PAT_W-1:0]      out_boot_pattern,
  input  logic                  out_send_panel,
  input  logic                  out_send_boot,
  input  logic                  out_save_patterns,
  input  logic                  out_restore_hdmi_pulse,
  input  logic                  out_up_line_low,
  input  logic                  out_down_line_low,
  input  logic                  out_select_line_low,
  input  logic                  out_display_mode,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TMR_W = TIMER_BITS_DEF;

  typedef enum logic [1:0] {BOOT_IDLE, BOOT_HELD, BOOT_LOCKOUT, BOOT_SPARE} boot_state_e;
  typedef enum logic [1:0] {LINE_UP, LINE_DOWN, LINE_SELECT} pulse_line_e;

  typedef struct packed {
    logic ext, sel, down, up, boot, kb, hdmi, acks;
  } panel_tick_t;

  typedef struct packed {
    logic [PAT_W-1:0] panel;
    logic [PAT_W-1:0] boot;
    logic             send_panel, send_boot, save, restore;
    logic             up_low, down_low, sel_low, display;
  } panel_result_t;

  // register copies
  logic [31:0]       code_bytes;
  logic [MAP_W-1:0]  slot_map;
  logic [TICK_W-1:0] rep_limit, long_limit, lock_limit, pulse_limit;

  // controller state copies
  logic              running, disp_on, pulse_on;
  logic [PAT_W-1:0]  panel_sw, boot_sw;
  logic              hdmi_armed, kb_armed, ext_armed;
  logic [TMR_W-1:0]  hdmi_age, kb_age, boot_age, pulse_age, ext_age;
  boot_state_e       boot_st;
  pulse_line_e       pulse_line;

  panel_result_t     expected_results [$];
  int                mismatches = 0;

  function automatic logic [PAT_W-1:0] pos_mask(int slot);
    logic [2:0] pos;
    pos = 3'(slot_map >> (3 * slot));
    return PAT_W'(1) << pos;
  endfunction

  // advance an elapsed counter, holding at its top value
  function automatic logic [TMR_W-1:0] age_up(logic [TMR_W-1:0] a);
    return (&a) ? a : a + 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // one 1 ms tick of the controller
  function automatic panel_result_t predict_tick(panel_tick_t t);
    panel_result_t    r;
    logic [PAT_W-1:0] m_hdmi, m_kb, m_disp, m_sel1, m_sel2;
    logic [1:0]       pick;
    r      = '0;
    m_hdmi = pos_mask(SLOT_HDMI_LED);
    m_kb   = pos_mask(SLOT_KB_SEL) | pos_mask(SLOT_KB_LED);
    m_disp = pos_mask(SLOT_DISP_LED);
    m_sel1 = pos_mask(SLOT_SEL1_LED);
    m_sel2 = pos_mask(SLOT_SEL2_LED);
    if (!running) begin
      // first acknowledge: send both patterns, buttons are not looked at
      if (t.acks) begin
        r.send_panel = 1'b1;
        r.send_boot  = 1'b1;
        r.restore    = |(panel_sw & m_hdmi);
        running      = 1'b1;
      end
    end else begin
      hdmi_age  = age_up(hdmi_age);
      kb_age    = age_up(kb_age);
      boot_age  = age_up(boot_age);
      pulse_age = age_up(pulse_age);
      ext_age   = age_up(ext_age);

      // end the line pulse once its time is up
      if (pulse_on && pulse_age > pulse_limit) pulse_on = 1'b0;

      // toggle buttons, repeating while held
      if (t.hdmi && (!hdmi_armed || hdmi_age > rep_limit)) begin
        panel_sw    ^= m_hdmi;
        r.send_panel = 1'b1;
        r.save       = 1'b1;
        hdmi_age     = '0;
        hdmi_armed   = 1'b1;
      end
      if (t.kb && (!kb_armed || kb_age > rep_limit)) begin
        panel_sw    ^= m_kb;
        r.send_panel = 1'b1;
        r.save       = 1'b1;
        kb_age       = '0;
        kb_armed     = 1'b1;
      end

      // boot button acts on release, then locks out
      case (boot_st)
        BOOT_HELD: begin
          if (!t.boot) begin
            if (boot_age > long_limit) begin
              disp_on  = !disp_on;
              panel_sw = disp_on ? (panel_sw | m_disp) : (panel_sw & ~m_disp);
            end else begin
              case ({|(panel_sw & m_sel2), |(panel_sw & m_sel1)})
                2'b00: begin
                  panel_sw |= m_sel1;
                  pick = 2'd1;
                end
                2'b01: begin
                  panel_sw = (panel_sw & ~m_sel1) | m_sel2;
                  pick = 2'd2;
                end
                2'b10: begin
                  panel_sw |= m_sel1;
                  pick = 2'd3;
                end
                default: begin
                  panel_sw &= ~(m_sel1 | m_sel2);
                  pick = 2'd0;
                end
              endcase
              boot_sw     = code_bytes[8 * pick +: 8];
              r.send_boot = 1'b1;
            end
            r.send_panel = 1'b1;
            r.save       = 1'b1;
            boot_age     = '0;
            boot_st      = BOOT_LOCKOUT;
          end
        end
        BOOT_LOCKOUT: begin
          if (boot_age > lock_limit) boot_st = BOOT_IDLE;
        end
        default: begin
          boot_st = BOOT_IDLE;
          if (t.boot) begin
            boot_age = '0;
            boot_st  = BOOT_HELD;
          end
        end
      endcase

      // start a line pulse in display mode, up over down over select
      if (disp_on && !pulse_on) begin
        if (t.up) begin
          pulse_line = LINE_UP;
          pulse_on   = 1'b1;
          pulse_age  = '0;
        end else if (t.down) begin
          pulse_line = LINE_DOWN;
          pulse_on   = 1'b1;
          pulse_age  = '0;
        end else if (t.sel) begin
          pulse_line = LINE_SELECT;
          pulse_on   = 1'b1;
          pulse_age  = '0;
        end
      end

      // external select request turns display mode on
      if (!disp_on && !pulse_on && t.ext && (!ext_armed || ext_age > rep_limit)) begin
        disp_on      = 1'b1;
        panel_sw    |= m_disp;
        r.send_panel = 1'b1;
        r.save       = 1'b1;
        ext_age      = '0;
        ext_armed    = 1'b1;
      end
    end
    r.panel    = panel_sw;
    r.boot     = boot_sw;
    r.up_low   = pulse_on && pulse_line == LINE_UP;
    r.down_low = pulse_on && pulse_line == LINE_DOWN;
    r.sel_low  = pulse_on && pulse_line == LINE_SELECT;
    r.display  = disp_on;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    panel_tick_t   tk;
    panel_result_t want;
    if (!rst_n) begin
      code_bytes  = '0;
      slot_map    = MAP_RST;
      rep_limit   = REPEAT_RST;
      long_limit  = LONG_PRESS_RST;
      lock_limit  = LOCKOUT_RST;
      pulse_limit = PULSE_RST;
      running     = 1'b0;
      panel_sw    = '0;
      boot_sw     = '0;
      hdmi_armed  = 1'b0;
      kb_armed    = 1'b0;
      ext_armed   = 1'b0;
      hdmi_age    = '0;
      kb_age      = '0;
      boot_age    = '0;
      pulse_age   = '0;
      ext_age     = '0;
      boot_st     = BOOT_IDLE;
      disp_on     = 1'b0;
      pulse_on    = 1'b0;
      pulse_line  = LINE_UP;
      expected_results.delete();
    end else begin
      // register writes take effect at once
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_STORED_PANEL: panel_sw = cfg_wdata[PAT_W-1:0] & ~pos_mask(SLOT_DISP_LED);
          REG_STORED_BOOT:  boot_sw = cfg_wdata[PAT_W-1:0];
          REG_BOOT_CODES:   code_bytes = cfg_wdata;
          REG_BIT_MAP:      slot_map = cfg_wdata[MAP_W-1:0];
          REG_REPEAT:       rep_limit = cfg_wdata[TICK_W-1:0];
          REG_LONG_PRESS:   long_limit = cfg_wdata[TICK_W-1:0];
          REG_LOCKOUT:      lock_limit = cfg_wdata[TICK_W-1:0];
          REG_PULSE:        pulse_limit = cfg_wdata[TICK_W-1:0];
          default: ;
        endcase
      end

      // compare a result transfer with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: panel_pattern %0d, boot_pattern %0d",
                 out_panel_pattern, out_boot_pattern);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("panel_pattern", want.panel, out_panel_pattern);
          check_field("boot_pattern", want.boot, out_boot_pattern);
          check_field("send_panel", want.send_panel, out_send_panel);
          check_field("send_boot", want.send_boot, out_send_boot);
          check_field("save_patterns", want.save, out_save_patterns);
          check_field("restore_hdmi_pulse", want.restore, out_restore_hdmi_pulse);
          check_field("up_line_low", want.up_low, out_up_line_low);
          check_field("down_line_low", want.down_low, out_down_line_low);
          check_field("select_line_low", want.sel_low, out_select_line_low);
          check_field("display_mode", want.display, out_display_mode);
        end
      end

      // predict each tick transfer
      if (in_valid && in_ready) begin
        tk = {in_ext_select_low, in_select_btn_low, in_down_btn_low, in_up_btn_low,
              in_boot_btn_low, in_kb_btn_low, in_hdmi_btn_low, in_device_acks};
        expected_results.push_back(predict_tick(tk));
      end
    end
    pending    <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives ticks and register settings into the front panel button controller.
// A directed opening covers startup, the restore pulse, toggles, both boot
// press lengths and line pulses; random phases then hold and release buttons
// over varied timer and bit-map settings, with throttling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import fpbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES  = 10;
  localparam int DRAIN_CYCLES  = 4;
  localparam int RESULT_HOLD   = 80;
  localparam int PHASES        = 8;
  localparam int STEADY_PHASE  = 1;
  localparam int HOLD_PHASE    = 2;
  localparam int DRAIN_PHASE   = 4;
  localparam int PHASE_TICKS   = 95;
  localparam int LONG_TICKS    = 300;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  // button slots of the random press generator, in tick bit order above acks
  localparam int BTN_HDMI = 0;
  localparam int BTN_KB   = 1;
  localparam int BTN_BOOT = 2;
  localparam int BTN_UP   = 3;
  localparam int BTN_DOWN = 4;
  localparam int BTN_SEL  = 5;
  localparam int BTN_EXT  = 6;
  localparam int NUM_BTNS = 7;

  typedef struct packed {
    logic [PAT_W-1:0]  panel;
    logic [PAT_W-1:0]  boot;
    logic [31:0]       codes;
    logic [MAP_W-1:0]  map;
    logic [TICK_W-1:0] rep, lng, lock, pulse;
  } panel_settings_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_device_acks = 1'b0;
  logic                  in_hdmi_btn_low = 1'b0;
  logic                  in_kb_btn_low = 1'b0;
  logic                  in_boot_btn_low = 1'b0;
  logic                  in_up_btn_low = 1'b0;
  logic                  in_down_btn_low = 1'b0;
  logic                  in_select_btn_low = 1'b0;
  logic                  in_ext_select_low = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PAT_W-1:0]      out_panel_pattern;
  logic [PAT_W-1:0]      out_boot_pattern;
  logic                  out_send_panel;
  logic                  out_send_boot;
  logic                  out_save_patterns;
  logic                  out_restore_hdmi_pulse;
  logic                  out_up_line_low;
  logic                  out_down_line_low;
  logic                  out_select_line_low;
  logic                  out_display_mode;
  int                    fail_count;
  int                    pending;

  panel_settings_t       cfg_now;
  logic                  steady = 1'b0;
  logic                  hold_results = 1'b0;
  logic [NUM_BTNS-1:0]   btn_level = '0;
  int                    btn_left [NUM_BTNS];
  int                    ticks_sent = 0;

  front_panel_button_controller_unit dut (.*);

  panel_result_checker u_check (.*);

  always #5 clk = ~clk;

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // offer one tick and hold it until the transfer
  task automatic send_tick(logic [7:0] t);
    while (!steady && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_ext_select_low, in_select_btn_low, in_down_btn_low, in_up_btn_low,
     in_boot_btn_low, in_kb_btn_low, in_hdmi_btn_low, in_device_acks} <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // stop offering and wait for every predicted result to arrive
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: random back-pressure, plus one long hold-off on request
  initial begin : result_sink
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_ready <= 1'b0;
        repeat (RESULT_HOLD) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] opening [$];
    logic [7:0] t;
    int         n;
    int         reach;
    // bits: ext, select, down, up, boot, kb, hdmi, acks
    opening = '{
      8'b1111_1110,  // buttons before any acknowledge are ignored
      8'b0000_0000,
      8'b1111_1111,  // start tick, HDMI bit set so a restore pulse is due
      8'b0000_0011,  // HDMI press toggles
      8'b0000_0011,
      8'b0000_0011,
      8'b0000_0011,  // held past the repeat interval, toggles again
      8'b0000_0101,  // KB press toggles both of its bits
      8'b0000_1001,  // boot press
      8'b0000_0001,  // short release cycles the boot selection
      8'b0000_0001,
      8'b0000_1001,  // lockout ends, press not yet seen
      8'b0000_1001,
      8'b0000_1001,
      8'b0000_1001,
      8'b0000_1001,
      8'b0000_1001,
      8'b0000_0001,  // long release turns display mode on
      8'b0111_0001,  // up wins over down and select
      8'b0011_0001,  // pulse still running
      8'b0011_0001,  // pulse ends, up starts again
      8'b1000_0001,  // external select ignored in display mode
      8'b0000_0001
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      // choose this phase's register setting
      cfg_now.panel = 8'($urandom);
      cfg_now.boot  = 8'($urandom);
      cfg_now.codes = $urandom;
      cfg_now.map   = MAP_W'($urandom);
      cfg_now.rep   = TICK_W'($urandom_range(1, 16));
      cfg_now.lng   = TICK_W'($urandom_range(1, 24));
      cfg_now.lock  = TICK_W'($urandom_range(1, 16));
      cfg_now.pulse = TICK_W'($urandom_range(1, 12));
      case (p)
        0: begin
          cfg_now.panel = 8'hFF;
          cfg_now.boot  = 8'hA5;
          cfg_now.codes = 32'h8421_C35A;
          cfg_now.map   = MAP_RST;
          cfg_now.rep   = TICK_W'(2);
          cfg_now.lng   = TICK_W'(3);
          cfg_now.lock  = TICK_W'(1);
          cfg_now.pulse = TICK_W'(1);
        end
        STEADY_PHASE: begin
          cfg_now.panel = '0;
          cfg_now.boot  = '0;
          cfg_now.codes = '0;
          cfg_now.map   = '0;
          cfg_now.rep   = TICK_W'(1);
          cfg_now.lng   = TICK_W'(1);
          cfg_now.lock  = TICK_W'(1);
          cfg_now.pulse = TICK_W'(1);
        end
        HOLD_PHASE: begin
          cfg_now.panel = '1;
          cfg_now.boot  = '1;
          cfg_now.codes = '1;
          cfg_now.map   = '1;
        end
        PHASES - 1: begin
          cfg_now.rep   = '1;
          cfg_now.lng   = '1;
          cfg_now.lock  = '1;
          cfg_now.pulse = '1;
        end
        default: ;
      endcase

      // load every register while the block is idle
      cfg_put(REG_STORED_PANEL, CFG_DATA_W'(cfg_now.panel));
      cfg_put(REG_STORED_BOOT, CFG_DATA_W'(cfg_now.boot));
      cfg_put(REG_BOOT_CODES, CFG_DATA_W'(cfg_now.codes));
      cfg_put(REG_BIT_MAP, CFG_DATA_W'(cfg_now.map));
      cfg_put(REG_REPEAT, CFG_DATA_W'(cfg_now.rep));
      cfg_put(REG_LONG_PRESS, CFG_DATA_W'(cfg_now.lng));
      cfg_put(REG_LOCKOUT, CFG_DATA_W'(cfg_now.lock));
      cfg_put(REG_PULSE, CFG_DATA_W'(cfg_now.pulse));
      cfg_wr_en <= 1'b0;
      steady = (p == STEADY_PHASE);

      if (p == 0) begin
        foreach (opening[k]) send_tick(opening[k]);
      end else begin
        n = (p == PHASES - 1) ? LONG_TICKS : PHASE_TICKS;
        for (int i = 0; i < n; i++) begin
          if (p == HOLD_PHASE && i == 20) hold_results = 1'b1;
          if (p == DRAIN_PHASE && i == 60) wait_drained();

          // hold and release each button for spans around its timer
          for (int b = 0; b < NUM_BTNS; b++) begin
            if (btn_left[b] == 0) begin
              case (b)
                BTN_BOOT: reach = (cfg_now.lng > cfg_now.lock) ? cfg_now.lng : cfg_now.lock;
                BTN_UP, BTN_DOWN, BTN_SEL: reach = cfg_now.pulse;
                BTN_HDMI, BTN_KB, BTN_EXT: reach = cfg_now.rep;
                default: reach = cfg_now.rep;
              endcase
              btn_level[b] = !btn_level[b];
              case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: btn_left[b] = $urandom_range(1, 6);
                6, 7, 8: btn_left[b] = $urandom_range(1, reach + 3);
                default: btn_left[b] = $urandom_range(reach, reach + 4);
              endcase
            end
            btn_left[b] = btn_left[b] - 1;
          end
          t = {btn_level, 1'($urandom)};
          // drop in some noise ticks that break the press sequences
          if ($urandom_range(0, 99) < 12) t = 8'($urandom);
          send_tick(t);
        end
      end
      wait_drained();
    end

    $display("Covered %0d ticks over %0d register settings: startup, toggles, boot presses,",
             ticks_sent, PHASES);
    $display("line pulses, timers at their longest settings and a long result hold-off.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/fpbc_pkg.sv
hdl/front_panel_button_controller_unit.sv
verif/panel_result_checker.sv
verif/tb_top.sv
